>>> src/bfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfb_pkg
// Shared types and constants of the free-space bitmap allocator.
// ----------------------------------------------------------------------------
package bfb_pkg;

    // field widths fixed by the request and result words
    localparam int IDX_W      = 14;
    localparam int BIT_W      = 6;
    localparam int WORD_IDX_W = IDX_W - BIT_W;
    localparam int MAP_WORD_W = 64;
    localparam int SECTORS_W  = 3;
    localparam int CMD_W      = 2;

    // words that a 14-bit block number can reach
    localparam int IDX_LIMIT_WORDS = 2 ** WORD_IDX_W;

    // full flags looked at per scan cycle
    localparam int SCAN_GROUP = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEST      = 2'd0,
        CMD_FIND      = 2'd1,
        CMD_MARK_USED = 2'd2,
        CMD_MARK_FREE = 2'd3
    } cmd_e;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] block_index;
    } in_word_t;

    typedef struct packed {
        logic             is_free;
        logic [IDX_W-1:0] found_block;
        logic             none_free;
    } out_word_t;

    // classified request handed from front to back
    typedef struct packed {
        cmd_e                  cmd;
        logic [WORD_IDX_W-1:0] word_idx;
        logic [BIT_W-1:0]      bit_sel;
        logic                  in_map;
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } back_state_e;

endpackage

>>> src/bfb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfb_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bfb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfb_front
// Accepts request words, splits the block number and queues the result.
// ----------------------------------------------------------------------------
module bfb_front #(
    parameter int USED_WORDS = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bfb_pkg::in_word_t s_data,
    output logic             op_valid,
    output bfb_pkg::op_t     op_data,
    input  logic             op_pop
);

    localparam int DEPTH = 2;

    bfb_pkg::op_t entry_reg [DEPTH];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    bfb_pkg::op_t classified;
    logic         push;

    // classify the incoming word
    always_comb begin
        classified.cmd      = bfb_pkg::cmd_e'(s_data.command);
        classified.word_idx = s_data.block_index[bfb_pkg::IDX_W-1:bfb_pkg::BIT_W];
        classified.bit_sel  = s_data.block_index[bfb_pkg::BIT_W-1:0];
        classified.in_map   = (32'(classified.word_idx) < 32'(USED_WORDS));
    end

    assign s_ready  = (count_reg != 2'(DEPTH));
    assign push     = s_valid && s_ready;
    assign op_valid = (count_reg != 2'd0);
    assign op_data  = entry_reg[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = op_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(op_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(DEPTH))
        else $error("front queue count past depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        op_pop |-> count_reg != 2'd0)
        else $error("pop from empty front queue");

    a_push_pop_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && op_pop) |=> $stable(count_reg))
        else $error("simultaneous push and pop changed count");

endmodule

>>> src/bfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfb_back
// Executes queued requests against the bitmap RAM and the full-word flags.
// ----------------------------------------------------------------------------
module bfb_back #(
    parameter int USED_WORDS   = 256,
    parameter int SECTOR_BYTES = 512
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [bfb_pkg::SECTORS_W-1:0]        map_sectors,
    input  logic                                op_valid,
    input  bfb_pkg::op_t                        op_data,
    output logic                                op_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bfb_pkg::out_word_t                  m_data
);

    localparam int AW        = $clog2(USED_WORDS);
    localparam int G         = bfb_pkg::SCAN_GROUP;
    localparam int GB        = $clog2(G);
    localparam int NGROUPS   = (USED_WORDS + G - 1) / G;
    localparam int GRP_W     = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int LW        = $clog2(USED_WORDS + 1);
    localparam int CW        = LW + 1;
    localparam int SEC_WORDS = SECTOR_BYTES / 8;
    localparam int PW        = $clog2(((2 ** bfb_pkg::SECTORS_W) - 1) * SEC_WORDS + 1);
    localparam int DW        = bfb_pkg::MAP_WORD_W;

    bfb_pkg::back_state_e state_reg, state_next;
    bfb_pkg::op_t         cur_reg;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [GRP_W-1:0]     group_reg;
    logic [G-1:0]         word_valid_reg [NGROUPS];
    logic [G-1:0]         full_reg [NGROUPS];
    logic                 out_valid_reg;
    bfb_pkg::out_word_t   out_reg, out_next;
    logic                 out_load;

    logic [GRP_W-1:0]     addr_grp;
    logic [GB-1:0]        addr_sel;
    logic [G-1:0]         group_full;

    logic [PW-1:0]        sec_prod;
    logic [LW-1:0]        limit_words;
    logic [CW-1:0]        base;
    logic                 scan_hit;
    logic [GB-1:0]        scan_sel;
    logic                 scan_last;
    logic                 out_free;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [DW-1:0]        ram_rdata, word_eff, new_word;
    logic                 zero_found;
    logic [bfb_pkg::BIT_W-1:0] zero_pos;
    logic                 group_step;

    // flag row and column of the current word
    assign addr_grp = GRP_W'(addr_reg >> GB);
    assign addr_sel = addr_reg[GB-1:0];

    // search bound in words, saturated at the stored map
    always_comb begin
        sec_prod = PW'(map_sectors) * PW'(SEC_WORDS);
        if (sec_prod > PW'(USED_WORDS)) begin
            limit_words = LW'(USED_WORDS);
        end else begin
            limit_words = sec_prod[LW-1:0];
        end
    end

    // full flags of the group being scanned
    assign group_full = full_reg[group_reg];

    // first word in the current group that is in range and not full
    always_comb begin
        logic [CW-1:0] w;
        base     = CW'(group_reg) << GB;
        scan_hit = 1'b0;
        scan_sel = '0;
        for (int j = G - 1; j >= 0; j--) begin
            w = base + CW'(j);
            if ((w < CW'(limit_words)) && (w < CW'(USED_WORDS)) && !group_full[j]) begin
                scan_hit = 1'b1;
                scan_sel = GB'(j);
            end
        end
        scan_last = ((base + CW'(G)) >= CW'(limit_words));
    end

    // word as stored, never-written words read as all free
    assign word_eff = word_valid_reg[addr_grp][addr_sel] ? ram_rdata : '0;

    // lowest clear bit of the word for find
    always_comb begin
        zero_found = 1'b0;
        zero_pos   = '0;
        for (int k = DW - 1; k >= 0; k--) begin
            if (!word_eff[k]) begin
                zero_found = 1'b1;
                zero_pos   = bfb_pkg::BIT_W'(k);
            end
        end
    end

    // updated word for the mark commands
    always_comb begin
        new_word = word_eff;
        if (cur_reg.cmd == bfb_pkg::CMD_MARK_USED) begin
            new_word[cur_reg.bit_sel] = 1'b1;
        end else begin
            new_word[cur_reg.bit_sel] = 1'b0;
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bfb_pkg::ST_IDLE: begin
                if (op_valid && out_free) begin
                    if (op_data.cmd == bfb_pkg::CMD_FIND) begin
                        state_next = bfb_pkg::ST_SCAN;
                    end else begin
                        state_next = bfb_pkg::ST_EXEC;
                    end
                end
            end
            bfb_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    state_next = bfb_pkg::ST_EXEC;
                end else if (scan_last) begin
                    state_next = bfb_pkg::ST_IDLE;
                end
            end
            bfb_pkg::ST_EXEC: begin
                state_next = bfb_pkg::ST_IDLE;
            end
            default: begin
                state_next = bfb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of each state
    always_comb begin
        op_pop     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = addr_reg;
        ram_we     = 1'b0;
        addr_next  = addr_reg;
        group_step = 1'b0;
        out_load   = 1'b0;
        out_next   = '0;
        unique case (state_reg)
            bfb_pkg::ST_IDLE: begin
                if (op_valid && out_free) begin
                    op_pop = 1'b1;
                    if (op_data.cmd != bfb_pkg::CMD_FIND) begin
                        ram_re    = 1'b1;
                        ram_raddr = op_data.word_idx[AW-1:0];
                        addr_next = op_data.word_idx[AW-1:0];
                    end
                end
            end
            bfb_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(base + CW'(scan_sel));
                    addr_next = AW'(base + CW'(scan_sel));
                end else if (scan_last) begin
                    out_load           = 1'b1;
                    out_next.none_free = 1'b1;
                end else begin
                    group_step = 1'b1;
                end
            end
            bfb_pkg::ST_EXEC: begin
                out_load = 1'b1;
                unique case (cur_reg.cmd)
                    bfb_pkg::CMD_TEST: begin
                        out_next.is_free = cur_reg.in_map && !word_eff[cur_reg.bit_sel];
                    end
                    bfb_pkg::CMD_FIND: begin
                        out_next.none_free   = !zero_found;
                        out_next.found_block = zero_found
                            ? {bfb_pkg::WORD_IDX_W'(addr_reg), zero_pos} : '0;
                    end
                    default: begin
                        ram_we = cur_reg.in_map;
                    end
                endcase
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bfb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NGROUPS; i++) begin
                word_valid_reg[i] <= '0;
                full_reg[i]       <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                word_valid_reg[addr_grp][addr_sel] <= 1'b1;
                full_reg[addr_grp][addr_sel]       <= &new_word;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        if (op_pop) begin
            cur_reg   <= op_data;
            group_reg <= '0;
        end else if (group_step) begin
            group_reg <= group_reg + GRP_W'(1);
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    bfb_ram #(
        .WIDTH (DW),
        .DEPTH (USED_WORDS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (new_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_pop_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        op_pop |-> out_free)
        else $error("request taken while result register busy");

    a_exec_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bfb_pkg::ST_EXEC) |-> $past(ram_re))
        else $error("execute without a preceding RAM read");

    a_write_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> word_valid_reg[$past(addr_grp)][$past(addr_sel)])
        else $error("written word not marked valid");

    a_load_needs_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_valid_reg) |-> m_ready)
        else $error("result overwritten before it was taken");

endmodule

>>> src/block_free_bitmap.sv
`timescale 1ns / 1ps
// Sequence: test and mark read the word from RAM, then give a result word; marks also
//   write the updated word back when it is in the map. Find scans full flags in groups
//   of 16 (1 to 16 groups), reads the chosen word, or gives none_free from the scan.
// Overlap: a new request is taken from the queue only when idle and the result is free.
// Reset: synchronous, active low; per-word valid bits make every word read as free,
//   full flags clear, map_sectors returns to 4, no clearing pass.
// ----------------------------------------------------------------------------
// block_free_bitmap
// Free-space bitmap allocator: test, find first free, mark used, mark free.
// ----------------------------------------------------------------------------
module block_free_bitmap #(
    parameter int MAP_BYTES    = 2048,
    parameter int SECTOR_BYTES = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bfb_pkg::SECTORS_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bfb_pkg::in_word_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bfb_pkg::out_word_t            m_data
);

    localparam int MAP_WORDS  = MAP_BYTES / 8;
    localparam int USED_WORDS = (MAP_WORDS < bfb_pkg::IDX_LIMIT_WORDS)
                                ? MAP_WORDS : bfb_pkg::IDX_LIMIT_WORDS;

    logic [bfb_pkg::SECTORS_W-1:0] map_sectors_reg;
    logic                          op_valid;
    bfb_pkg::op_t                  op_data;
    logic                          op_pop;

    // sector count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_sectors_reg <= bfb_pkg::SECTORS_W'(4);
        end else if (cfg_we) begin
            map_sectors_reg <= cfg_data;
        end
    end

    bfb_front #(
        .USED_WORDS (USED_WORDS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .op_valid (op_valid),
        .op_data  (op_data),
        .op_pop   (op_pop)
    );

    bfb_back #(
        .USED_WORDS   (USED_WORDS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .map_sectors (map_sectors_reg),
        .op_valid    (op_valid),
        .op_data     (op_data),
        .op_pop      (op_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
